/* src/integer_fold_alu_core_assert.svh */
// ----------------------------------------------------------------------------
// integer_fold_alu_core_assert.svh
// Assertion macros for the integer fold ALU.
// ----------------------------------------------------------------------------
`ifndef INTEGER_FOLD_ALU_CORE_ASSERT_SVH
`define INTEGER_FOLD_ALU_CORE_ASSERT_SVH
`ifndef SYNTH
`define IFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IFA_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IFA_ASSERT(label, clk, rst_n, prop, msg)
`define IFA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* src/ifa_pkg.sv */
// ----------------------------------------------------------------------------
// ifa_pkg
// Types and constants shared by the integer fold ALU modules.
// ----------------------------------------------------------------------------
package ifa_pkg;

    localparam int DataWidth = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
        OP_MOD = 3'd4, OP_POW = 3'd5, OP_MIN = 3'd6, OP_MAX = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_DIV0 = 2'd1, ERR_NEGEXP = 2'd2
    } err_t;

    typedef struct packed {
        logic [2:0]                  req_type;
        logic signed [DataWidth-1:0] operand;
        logic                        is_first;
        logic                        is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic [1:0]                  error_code;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_POW, ST_MUL, ST_FIN, ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item, start the fold on a first item
        logic div_step; // one restoring divide step
        logic pow_step; // one phase of a square-and-multiply step
        logic mul_step; // one multiply partial step
        logic finish;   // do simple folds, latch errors, set up the iterative unit
        logic emit;     // capture result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic need_pow;
        logic need_mul;
        logic iter_done;
        logic emit_req;
    } status_t;

endpackage

/* src/ifa_ctrl.sv */
// ----------------------------------------------------------------------------
// ifa_ctrl
// Sequencer: accepts an item, runs the iterative unit, hands off result.
// ----------------------------------------------------------------------------
module ifa_ctrl
    import ifa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    out_busy,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.need_div)
                    state_next = ST_DIV;
                else if (status.need_pow)
                    state_next = ST_POW;
                else if (status.need_mul)
                    state_next = ST_MUL;
                else if (status.emit_req)
                    state_next = ST_OUT;
                else
                    state_next = ST_IDLE;
            end
            ST_DIV, ST_POW, ST_MUL:
            begin
                if (status.iter_done)
                    state_next = status.emit_req ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DIV: cmd.div_step = 1'b1;
            ST_POW: cmd.pow_step = 1'b1;
            ST_MUL: cmd.mul_step = 1'b1;
            ST_FIN: cmd.finish   = 1'b1;
            ST_OUT: cmd.emit     = !out_busy;
            default: ;
        endcase
    end

endmodule

/* src/ifa_datapath.sv */
// ----------------------------------------------------------------------------
// ifa_datapath
// Accumulator, error latch and a shared iterative unit for mul, div, mod, pow.
// ----------------------------------------------------------------------------
module ifa_datapath
    import ifa_pkg::*;
#(
    parameter int W = DataWidth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  cmd_t      cmd,
    output status_t   status,
    output out_item_t result
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    err_t          err_reg, err_next;
    logic [W-1:0]  y_reg;
    op_t           op_reg;
    logic          last_reg, fold_reg;
    // iterative unit
    logic [W-1:0]  a_reg;    // multiplicand / divisor mag / base
    logic [W-1:0]  b_reg;    // multiplier / quotient-dividend / exponent
    logic [W-1:0]  p_reg;    // product / remainder / pow result
    logic [W-1:0]  t_reg;    // pow: product under construction
    logic [CW-1:0] cnt_reg;
    logic          qneg_reg, rneg_reg;
    logic [1:0]    ph_reg;   // pow phase: 0 latch result, 1 multiply and square
    logic          done_reg;

    logic [W-1:0]  acc_mag, y_mag;
    logic          lt;
    logic [W:0]    rtrial;

    // low W bits of a product from 32-bit halves
    function automatic logic [W-1:0] mul_lo(input logic [W-1:0] x, input logic [W-1:0] z);
        logic [W-1:0] ll, lh, hl;
        begin
            ll = W'(x[W/2-1:0] * z[W/2-1:0]);
            lh = W'(x[W/2-1:0] * z[W-1:W/2]);
            hl = W'(x[W-1:W/2] * z[W/2-1:0]);
            mul_lo = ll + ((lh + hl) << (W / 2));
        end
    endfunction

    assign acc_mag = acc_reg[W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign y_mag   = y_reg[W-1]   ? (~y_reg + 1'b1)   : y_reg;
    assign lt      = $signed(acc_reg) < $signed(y_reg);
    assign rtrial  = {p_reg, b_reg[W-1]} - {1'b0, a_reg};

    // decode of the captured item
    logic need_div, need_pow, need_mul;
    assign need_div = fold_reg && (op_reg == OP_DIV || op_reg == OP_MOD) && (y_reg != '0);
    assign need_pow = fold_reg && (op_reg == OP_POW) && !y_reg[W-1];
    assign need_mul = fold_reg && (op_reg == OP_MUL);

    assign status.need_div  = need_div;
    assign status.need_pow  = need_pow;
    assign status.need_mul  = need_mul;
    assign status.iter_done = done_reg;
    assign status.emit_req  = last_reg;

    // capture item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            y_reg    <= in_item.operand;
            op_reg   <= op_t'(in_item.req_type);
            last_reg <= in_item.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_reg <= 1'b0;
        else if (cmd.load)
            fold_reg <= !in_item.is_first && (err_reg == ERR_NONE);
    end

    // accumulator and error latch
    always_comb
    begin
        acc_next = acc_reg;
        err_next = err_reg;
        if (cmd.load && in_item.is_first)
        begin
            err_next = ERR_NONE;
            acc_next = (in_item.req_type == OP_SUB && in_item.is_last)
                     ? (~in_item.operand + 1'b1) : in_item.operand;
        end
        else if (cmd.finish && fold_reg)
        begin
            case (op_reg)
                OP_ADD: acc_next = acc_reg + y_reg;
                OP_SUB: acc_next = acc_reg - y_reg;
                OP_MIN: acc_next = lt ? acc_reg : y_reg;
                OP_MAX: acc_next = lt ? y_reg : acc_reg;
                OP_DIV, OP_MOD:
                begin
                    if (y_reg == '0)
                        err_next = ERR_DIV0;
                end
                OP_POW:
                begin
                    if (y_reg[W-1])
                        err_next = ERR_NEGEXP;
                end
                default: ;
            endcase
        end
        else if (done_reg && fold_reg)
        begin
            case (op_reg)
                OP_DIV:  acc_next = qneg_reg ? (~b_reg + 1'b1) : b_reg;
                OP_MOD:  acc_next = rneg_reg ? (~p_reg + 1'b1) : p_reg;
                default: acc_next = p_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            err_reg <= ERR_NONE;
        end
        else
        begin
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
    end

    // shared iterative unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            ph_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.finish)
            begin
                cnt_reg <= '0;
                ph_reg  <= '0;
            end
            else if (cmd.mul_step || cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                    done_reg <= 1'b1;
            end
            else if (cmd.pow_step && !done_reg)
            begin
                ph_reg <= ph_reg + 1'b1;
                if (ph_reg == 2'd1)
                begin
                    ph_reg <= '0;
                    if (b_reg == '0 || cnt_reg == CW'(W - 1))
                        done_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            qneg_reg <= acc_reg[W-1] ^ y_reg[W-1];
            rneg_reg <= acc_reg[W-1];
            case (op_reg)
                OP_DIV, OP_MOD:
                begin
                    a_reg <= y_mag;
                    b_reg <= acc_mag;
                    p_reg <= '0;
                end
                OP_POW:
                begin
                    a_reg <= acc_reg;
                    b_reg <= y_reg;
                    p_reg <= W'(1);
                end
                default:
                begin
                    a_reg <= acc_reg;
                    b_reg <= y_reg;
                    p_reg <= '0;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            // restoring divide: b shifts out dividend, shifts in quotient
            if (!rtrial[W])
            begin
                p_reg <= rtrial[W-1:0];
                b_reg <= {b_reg[W-2:0], 1'b1};
            end
            else
            begin
                p_reg <= {p_reg[W-2:0], b_reg[W-1]};
                b_reg <= {b_reg[W-2:0], 1'b0};
            end
        end
        else if (cmd.mul_step)
        begin
            // shift-add, low bits of product only
            if (b_reg[0])
                p_reg <= p_reg + a_reg;
            a_reg <= {a_reg[W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[W-1:1]};
        end
        else if (cmd.pow_step && !done_reg)
        begin
            // phase 0: latch result if bit set; phase 1: result *= base if bit set, base *= base
            // each product formed by a 32x32-limited split over halves
            if (ph_reg == 2'd0)
                t_reg <= b_reg[0] ? p_reg : '0;
            else
            begin
                if (b_reg[0])
                    p_reg <= mul_lo(t_reg, a_reg);
                a_reg <= mul_lo(a_reg, a_reg);
                b_reg <= {1'b0, b_reg[W-1:1]};
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result.value      <= (err_reg == ERR_NONE) ? acc_reg : '0;
            result.error_code <= err_reg;
        end
    end

endmodule

/* src/integer_fold_alu_core.sv */
// ----------------------------------------------------------------------------
// integer_fold_alu_core
// Folds a list of signed 64-bit operands under add, sub, mul, div, mod,
// pow, min or max, one operand per item, with a result on the last item.
// ----------------------------------------------------------------------------
// One item at a time. Add, sub, min, max, first items, skipped items and
// error cases take the short path through the finish state; mul, divide and
// remainder run one bit per cycle on the shared iterative unit; pow runs a
// latch phase and a multiply-and-square phase per exponent bit through its
// highest set bit plus one more pair. A last item also loads the output
// register, once any previous result stalled there has been taken.
module integer_fold_alu_core
    import ifa_pkg::*;
#(
    parameter int W = DataWidth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

`include "integer_fold_alu_core_assert.svh"

    cmd_t    cmd;
    status_t status;
    logic    out_valid_reg;

    ifa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_busy (out_valid_reg && out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ifa_datapath #(.W(W)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .status  (status),
        .result  (out_data)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    `IFA_ASSERT(a_emit_free, clk, rst_n, cmd.emit |-> !(out_valid_reg && out_stall), "emit over held item")
    `IFA_ASSERT(a_one_step, clk, rst_n, $onehot0({cmd.load, cmd.div_step, cmd.pow_step, cmd.mul_step, cmd.finish, cmd.emit}), "overlapping commands")
    `IFA_ASSERT(a_emit_valid, clk, rst_n, cmd.emit |=> out_valid, "result lost")

endmodule

/* verif/integer_fold_alu_core_checker.sv */
// ----------------------------------------------------------------------------
// integer_fold_alu_core_checker
// Watches both channels of the integer fold ALU, folds every accepted item
// into its own accumulator and compares each result against the oldest
// predicted one.
// ----------------------------------------------------------------------------
module integer_fold_alu_core_checker
    import ifa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] acc;
    err_t        err_latch;
    out_item_t   result_q[$];

    // truncating signed divide, quotient or remainder
    function automatic logic [63:0] sdivide(logic [63:0] a, logic [63:0] b, bit want_rem);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] r;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (want_rem)
            return a[63] ? -r : r;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] ipow(logic [63:0] base, logic [63:0] ex);
        logic [63:0] res;
        res = 64'd1;
        while (ex != 0)
        begin
            if (ex[0])
                res = res * base;
            base = base * base;
            ex = ex >> 1;
        end
        return res;
    endfunction

    // apply one accepted item to the running fold
    task automatic fold_item(in_item_t it);
        logic [63:0] y;
        out_item_t   res;
        y = it.operand;
        if (it.is_first)
        begin
            err_latch = ERR_NONE;
            acc = (op_t'(it.req_type) == OP_SUB && it.is_last) ? -y : y;
        end
        else if (err_latch == ERR_NONE)
        begin
            case (op_t'(it.req_type))
                OP_ADD: acc = acc + y;
                OP_SUB: acc = acc - y;
                OP_MUL: acc = acc * y;
                OP_DIV, OP_MOD:
                    if (y == 0)
                        err_latch = ERR_DIV0;
                    else
                        acc = sdivide(acc, y, op_t'(it.req_type) == OP_MOD);
                OP_POW:
                    if (y[63])
                        err_latch = ERR_NEGEXP;
                    else
                        acc = ipow(acc, y);
                OP_MIN: acc = ($signed(acc) < $signed(y)) ? acc : y;
                default: acc = ($signed(acc) < $signed(y)) ? y : acc;
            endcase
        end
        if (it.is_last)
        begin
            res.value = (err_latch == ERR_NONE) ? acc : 64'd0;
            res.error_code = err_latch;
            result_q.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc = '0;
            err_latch = ERR_NONE;
            fail_count <= 0;
        end
        else
        begin
            // result side first: an item's own result cannot appear this edge
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result value=%0d err=%0d", $time,
                             out_data.value, out_data.error_code);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    out_item_t exp_r;
                    exp_r = result_q.pop_front();
                    if (exp_r.value !== out_data.value)
                    begin
                        $display("%0t: value expected %0d actual %0d", $time,
                                 exp_r.value, out_data.value);
                        fail_count <= fail_count + 1;
                    end
                    else if (exp_r.error_code !== out_data.error_code)
                    begin
                        $display("%0t: error_code expected %0d actual %0d", $time,
                                 exp_r.error_code, out_data.error_code);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                fold_item(in_data);
        end
    end

    assign pending_count = result_q.size();
endmodule

/* verif/integer_fold_alu_core_tb.sv */
// ----------------------------------------------------------------------------
// integer_fold_alu_core_tb
// Drives directed and random operand lists into the integer fold ALU with
// random gaps and output stalls; the checker module does the prediction.
// ----------------------------------------------------------------------------
module integer_fold_alu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ifa_pkg::*;

    localparam longint CycleLimit = 1500000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    int        fail_count;
    int        pending_count;
    bit        hold_off;
    longint    cycle_count = 0;

    integer_fold_alu_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    integer_fold_alu_core_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // operand with a bias toward edge values
    function automatic logic [63:0] pick_operand(op_t op);
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'hffff_ffff_ffff_ffff;
            3: return 64'd0;
            4: return 64'(signed'($urandom_range(0, 20)) - 10);
            default:
                if (op == OP_POW && $urandom_range(0, 3) != 0)
                    return 64'($urandom_range(0, 70));
                else
                    return {$urandom(), $urandom()};
        endcase
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(op_t op, logic [63:0] y, bit first, bit last);
        in_data <= '{req_type: op, operand: y, is_first: first, is_last: last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_list(int len, bit mixed);
        op_t op;
        op = op_t'($urandom_range(0, 7));
        for (int i = 0; i < len; i++)
        begin
            if (mixed)
                op = op_t'($urandom_range(0, 7));
            send_item(op, pick_operand(op), i == 0, i == len - 1);
            send_gap(gap_len());
        end
    endtask

    // receiver stalls, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 3) == 0)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("integer_fold_alu_core_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int sent;
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single items, every op, edge cases
        for (int k = 0; k < 8; k++)
            send_item(op_t'(k), 64'd5, 1'b1, 1'b1);
        send_item(OP_SUB, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
        send_item(OP_ADD, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
        send_item(OP_DIV, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
        send_item(OP_ADD, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
        send_item(OP_MOD, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
        send_item(OP_ADD, 64'd7, 1'b1, 1'b0);
        send_item(OP_DIV, 64'd0, 1'b0, 1'b0);
        send_item(OP_ADD, 64'd3, 1'b0, 1'b1);
        send_item(OP_ADD, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);   // error still latched
        send_item(OP_ADD, 64'd3, 1'b1, 1'b0);
        send_item(OP_POW, 64'hffff_ffff_ffff_fffe, 1'b0, 1'b1);
        send_item(OP_ADD, 64'd3, 1'b1, 1'b0);
        send_item(OP_POW, 64'd0, 1'b0, 1'b1);
        send_item(OP_POW, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0);   // no list open
        send_item(OP_MAX, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1);
        send_item(OP_MIN, 64'h8000_0000_0000_0000, 1'b0, 1'b1);
        send_item(OP_MUL, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
        sent = 25;

        // sender waits for every result; it first lets the checker see the last item
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);

        // long receiver hold-off while items keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int j = 0; j < 6; j++)
                send_item(OP_ADD, {$urandom(), $urandom()}, 1'b1, 1'b1);
        join
        sent += 6;

        // random lists, mostly well formed, some stray items
        while (sent < 1150)
        begin
            int len;
            len = $urandom_range(1, 5);
            if ($urandom_range(0, 9) == 0)
            begin
                op_t op;
                op = op_t'($urandom_range(0, 7));
                send_item(op, pick_operand(op), 1'b0, 1'($urandom_range(0, 1)));
                len = 1;
            end
            else
                send_list(len, $urandom_range(0, 2) == 0);
            sent += len;
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending_count != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("integer_fold_alu_core_tb: done, clean");
        else
            $display("integer_fold_alu_core_tb: done, errors");
        $finish;
    end
endmodule
